/* rtl/fpa_pkg.sv */
// Shared types and constants of the first-fit pool allocator.
// Used by fpa_ctrl, fpa_dp, the top level and the checker.
package fpa_pkg;

  localparam int POOL_GRANULES = 65536;
  localparam int MEM_AW        = $clog2(POOL_GRANULES);
  localparam int IDX_W         = $clog2(POOL_GRANULES) + 1;
  localparam int SZ_W          = 21;
  localparam int F_W           = 20;
  localparam int CMP_W         = IDX_W + SZ_W;
  localparam int GRAN_BYTES    = 8;
  localparam int HDR_BYTES     = 8;
  localparam int MIN_REST      = 16;
  localparam logic [63:0] POOL_CAP = 64'(POOL_GRANULES) * 64'(GRAN_BYTES);
  localparam logic [F_W-1:0] POOL_RESET = 20'd524288;
  localparam int CFG_POOL_IDX  = 0;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_RESET = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_BAD_OFFSET = 2'd2
  } status_t;

  typedef struct packed {
    logic [SZ_W-1:0]  size;
    logic [IDX_W-1:0] next;
    logic             nok;
  } hdr_t;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_DEC, S_FORM,
    S_A_CHK, S_A_RD, S_A_EV, S_A_SPL1, S_A_SPL2, S_A_LNK,
    S_F_CHK, S_F_RDC, S_F_CSZ, S_F_W1, S_F_W1E, S_F_INS, S_F_LNK,
    S_F_W2I, S_F_W2, S_F_W2E, S_F_PM, S_F_SM, S_F_SME,
    S_Q_INIT, S_Q_RD, S_Q_EV,
    S_RESP_OK, S_RESP_AF, S_RESP_FR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_FORM, OP_W_INIT, OP_WALK_RD, OP_W_STEP,
    OP_A_EVAL, OP_A_SPL1, OP_A_SPL2, OP_LINK,
    OP_F_CUR, OP_RD_CUR, OP_F_CSZ, OP_F_INS, OP_F_PM, OP_RD_W1, OP_F_SME,
    OP_Q_STEP, OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  a_bad;
    logic  f_bad;
    logic  walk_go;
    logic  w1_go;
    logic  w2_go;
    logic  fit;
    logic  split;
    logic  merge_next;
  } dp_stat_t;

endpackage

/* rtl/fpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fpa_ctrl.sv */
// Sequencer of the pool allocator: walks each operation through its steps.
// Depends on fpa_pkg; drives fpa_dp through command and status structs.
module fpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::dp_stat_t stat,
  output fpa_pkg::dp_cmd_t  cmd
);

  fpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpa_pkg::S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpa_pkg::S_BOOT: state_nxt = fpa_pkg::S_IDLE;
      fpa_pkg::S_IDLE: if (start) state_nxt = fpa_pkg::S_DEC;
      fpa_pkg::S_DEC: begin
        unique case (stat.func)
          fpa_pkg::FN_ALLOC: state_nxt = fpa_pkg::S_A_CHK;
          fpa_pkg::FN_FREE:  state_nxt = fpa_pkg::S_F_CHK;
          fpa_pkg::FN_RESET: state_nxt = fpa_pkg::S_FORM;
          default:           state_nxt = fpa_pkg::S_Q_INIT;
        endcase
      end
      fpa_pkg::S_FORM:   state_nxt = fpa_pkg::S_RESP_OK;
      fpa_pkg::S_A_CHK:  state_nxt = stat.a_bad ? fpa_pkg::S_RESP_AF : fpa_pkg::S_A_RD;
      fpa_pkg::S_A_RD:   state_nxt = stat.walk_go ? fpa_pkg::S_A_EV : fpa_pkg::S_RESP_AF;
      fpa_pkg::S_A_EV: begin
        if (!stat.fit) begin
          state_nxt = fpa_pkg::S_A_RD;
        end else if (stat.split) begin
          state_nxt = fpa_pkg::S_A_SPL1;
        end else begin
          state_nxt = fpa_pkg::S_A_LNK;
        end
      end
      fpa_pkg::S_A_SPL1: state_nxt = fpa_pkg::S_A_SPL2;
      fpa_pkg::S_A_SPL2: state_nxt = fpa_pkg::S_A_LNK;
      fpa_pkg::S_A_LNK:  state_nxt = fpa_pkg::S_RESP_OK;
      fpa_pkg::S_F_CHK:  state_nxt = stat.f_bad ? fpa_pkg::S_RESP_FR : fpa_pkg::S_F_RDC;
      fpa_pkg::S_F_RDC:  state_nxt = fpa_pkg::S_F_CSZ;
      fpa_pkg::S_F_CSZ:  state_nxt = fpa_pkg::S_F_W1;
      fpa_pkg::S_F_W1:   state_nxt = stat.w1_go ? fpa_pkg::S_F_W1E : fpa_pkg::S_F_INS;
      fpa_pkg::S_F_W1E:  state_nxt = fpa_pkg::S_F_W1;
      fpa_pkg::S_F_INS:  state_nxt = fpa_pkg::S_F_LNK;
      fpa_pkg::S_F_LNK:  state_nxt = fpa_pkg::S_F_W2I;
      fpa_pkg::S_F_W2I:  state_nxt = fpa_pkg::S_F_W2;
      fpa_pkg::S_F_W2:   state_nxt = stat.w2_go ? fpa_pkg::S_F_W2E : fpa_pkg::S_F_PM;
      fpa_pkg::S_F_W2E:  state_nxt = fpa_pkg::S_F_W2;
      fpa_pkg::S_F_PM:   state_nxt = fpa_pkg::S_F_SM;
      fpa_pkg::S_F_SM:   state_nxt = stat.merge_next ? fpa_pkg::S_F_SME : fpa_pkg::S_RESP_OK;
      fpa_pkg::S_F_SME:  state_nxt = fpa_pkg::S_RESP_OK;
      fpa_pkg::S_Q_INIT: state_nxt = fpa_pkg::S_Q_RD;
      fpa_pkg::S_Q_RD:   state_nxt = stat.walk_go ? fpa_pkg::S_Q_EV : fpa_pkg::S_RESP_OK;
      fpa_pkg::S_Q_EV:   state_nxt = fpa_pkg::S_Q_RD;
      fpa_pkg::S_RESP_OK,
      fpa_pkg::S_RESP_AF,
      fpa_pkg::S_RESP_FR: state_nxt = fpa_pkg::S_IDLE;
      default:           state_nxt = fpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = fpa_pkg::OP_NONE;
    cmd.status = fpa_pkg::ST_DONE;
    busy       = (state_r != fpa_pkg::S_IDLE);
    unique case (state_r)
      fpa_pkg::S_BOOT,
      fpa_pkg::S_FORM:   cmd.op = fpa_pkg::OP_FORM;
      fpa_pkg::S_IDLE:   if (start) cmd.op = fpa_pkg::OP_CAPTURE;
      fpa_pkg::S_A_CHK,
      fpa_pkg::S_F_W2I,
      fpa_pkg::S_Q_INIT: cmd.op = fpa_pkg::OP_W_INIT;
      fpa_pkg::S_A_RD,
      fpa_pkg::S_Q_RD:   if (stat.walk_go) cmd.op = fpa_pkg::OP_WALK_RD;
      fpa_pkg::S_A_EV:   cmd.op = fpa_pkg::OP_A_EVAL;
      fpa_pkg::S_A_SPL1: cmd.op = fpa_pkg::OP_A_SPL1;
      fpa_pkg::S_A_SPL2: cmd.op = fpa_pkg::OP_A_SPL2;
      fpa_pkg::S_A_LNK,
      fpa_pkg::S_F_LNK:  cmd.op = fpa_pkg::OP_LINK;
      fpa_pkg::S_F_CHK:  cmd.op = fpa_pkg::OP_F_CUR;
      fpa_pkg::S_F_RDC:  cmd.op = fpa_pkg::OP_RD_CUR;
      fpa_pkg::S_F_CSZ:  cmd.op = fpa_pkg::OP_F_CSZ;
      fpa_pkg::S_F_W1:   if (stat.w1_go) cmd.op = fpa_pkg::OP_WALK_RD;
      fpa_pkg::S_F_W2:   if (stat.w2_go) cmd.op = fpa_pkg::OP_WALK_RD;
      fpa_pkg::S_F_W1E,
      fpa_pkg::S_F_W2E:  cmd.op = fpa_pkg::OP_W_STEP;
      fpa_pkg::S_F_INS:  cmd.op = fpa_pkg::OP_F_INS;
      fpa_pkg::S_F_PM:   cmd.op = fpa_pkg::OP_F_PM;
      fpa_pkg::S_F_SM:   if (stat.merge_next) cmd.op = fpa_pkg::OP_RD_W1;
      fpa_pkg::S_F_SME:  cmd.op = fpa_pkg::OP_F_SME;
      fpa_pkg::S_Q_EV:   cmd.op = fpa_pkg::OP_Q_STEP;
      fpa_pkg::S_RESP_OK: cmd.op = fpa_pkg::OP_RESP;
      fpa_pkg::S_RESP_AF: begin
        cmd.op     = fpa_pkg::OP_RESP;
        cmd.status = fpa_pkg::ST_ALLOC_FAIL;
      end
      fpa_pkg::S_RESP_FR: begin
        cmd.op     = fpa_pkg::OP_RESP;
        cmd.status = fpa_pkg::ST_BAD_OFFSET;
      end
      default:           cmd.op = fpa_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/fpa_dp.sv */
// Datapath of the pool allocator: walk registers, list head, header memory.
// Depends on fpa_pkg and fpa_ram; commanded by fpa_ctrl.
module fpa_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpa_pkg::dp_cmd_t          cmd,
  input  logic [1:0]                in_func,
  input  logic [fpa_pkg::F_W-1:0]   in_req_bytes,
  input  logic [fpa_pkg::F_W-1:0]   in_free_offset,
  input  logic [fpa_pkg::F_W-1:0]   pool_bytes,
  output fpa_pkg::dp_stat_t         stat,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [fpa_pkg::F_W-1:0]   out_payload_offset,
  output logic [fpa_pkg::F_W-1:0]   out_largest_free
);

  localparam int IW = fpa_pkg::IDX_W;
  localparam int SW = fpa_pkg::SZ_W;
  localparam int FW = fpa_pkg::F_W;
  localparam int CW = fpa_pkg::CMP_W;
  localparam logic [IW-1:0] GRAN_LIM = IW'(fpa_pkg::POOL_GRANULES);

  fpa_pkg::func_t   func_r;
  logic [FW-1:0]    req_r, off_r, pay_r;
  logic [IW-1:0]    head_r, wp_r, pv_r, cur_r, w1_r, base_r, nx_r, lnk_tgt_r, n_r;
  logic             head_ok_r, ok_r, hp_r, ok1_r, nok_r, lnk_ok_r, rd_oob_r;
  logic [SW-1:0]    pvsz_r, csz_r, bsz_r, sz_r, best_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [FW-1:0]    out_pay_r, out_big_r;

  logic [FW-1:0]    p_rnd, p_eff;
  logic [SW-1:0]    need, rnd;
  logic [IW-1:0]    r_idx, wa_idx, ra_idx;
  fpa_pkg::hdr_t    rd, wdata;
  logic             we_req, re_req, ram_we;
  logic [$bits(fpa_pkg::hdr_t)-1:0] ram_rdata;
  logic             pm_hit;
  logic [SW-1:0]    pm_sum;

  assign p_rnd = {pool_bytes[FW-1:3], 3'b000};
  assign p_eff = (64'(p_rnd) < fpa_pkg::POOL_CAP) ? p_rnd : fpa_pkg::POOL_CAP[FW-1:0];
  assign rnd   = (SW'(req_r) + SW'(7)) & ~SW'(7);
  assign need  = rnd + SW'(fpa_pkg::HDR_BYTES);
  assign r_idx = wp_r + IW'(need >> 3);
  assign rd    = rd_oob_r ? '0 : fpa_pkg::hdr_t'(ram_rdata);
  assign pm_sum = pvsz_r + csz_r;
  assign pm_hit = hp_r && ((CW'({pv_r, 3'b000}) + CW'(pvsz_r)) == CW'({cur_r, 3'b000}));

  always_comb begin
    stat.func       = func_r;
    stat.a_bad      = (req_r == '0) || (need > SW'(p_eff));
    stat.f_bad      = (off_r < FW'(fpa_pkg::HDR_BYTES)) || (off_r >= p_eff) ||
                      (off_r[2:0] != 3'b000);
    stat.walk_go    = ok_r && (n_r < GRAN_LIM);
    stat.w1_go      = ok_r && (n_r < GRAN_LIM) && (wp_r < cur_r);
    stat.w2_go      = ok_r && (n_r < GRAN_LIM) && (wp_r != cur_r);
    stat.fit        = rd.size >= need;
    stat.split      = (SW'(1) + rd.size) > (need + SW'(fpa_pkg::MIN_REST - 1));
    stat.merge_next = ok1_r &&
                      ((CW'({base_r, 3'b000}) + CW'(bsz_r)) == CW'({w1_r, 3'b000}));
  end

  // Memory port steering: one access per step, writes beyond the pool dropped.
  always_comb begin
    we_req = 1'b0;
    re_req = 1'b0;
    wa_idx = '0;
    ra_idx = wp_r;
    wdata  = '0;
    unique case (cmd.op)
      fpa_pkg::OP_FORM: begin
        we_req = (p_eff >= FW'(fpa_pkg::MIN_REST));
        wdata  = '{size: SW'(p_eff), next: '0, nok: 1'b0};
      end
      fpa_pkg::OP_WALK_RD: re_req = 1'b1;
      fpa_pkg::OP_RD_CUR: begin
        re_req = 1'b1;
        ra_idx = cur_r;
      end
      fpa_pkg::OP_RD_W1: begin
        re_req = 1'b1;
        ra_idx = w1_r;
      end
      fpa_pkg::OP_A_SPL1: begin
        we_req = 1'b1;
        wa_idx = wp_r;
        wdata  = '{size: need, next: nx_r, nok: nok_r};
      end
      fpa_pkg::OP_A_SPL2: begin
        we_req = 1'b1;
        wa_idx = r_idx;
        wdata  = '{size: sz_r - need, next: nx_r, nok: nok_r};
      end
      fpa_pkg::OP_LINK: begin
        we_req = hp_r;
        wa_idx = pv_r;
        wdata  = '{size: pvsz_r, next: lnk_tgt_r, nok: lnk_ok_r};
      end
      fpa_pkg::OP_F_INS: begin
        we_req = 1'b1;
        wa_idx = cur_r;
        wdata  = '{size: csz_r, next: wp_r, nok: ok_r};
      end
      fpa_pkg::OP_F_PM: begin
        we_req = pm_hit;
        wa_idx = pv_r;
        wdata  = '{size: pm_sum, next: w1_r, nok: ok1_r};
      end
      fpa_pkg::OP_F_SME: begin
        we_req = 1'b1;
        wa_idx = base_r;
        wdata  = '{size: bsz_r + rd.size, next: rd.next, nok: rd.nok};
      end
      default: ;
    endcase
  end

  assign ram_we = we_req && (wa_idx < GRAN_LIM);

  fpa_ram #(
    .WIDTH($bits(fpa_pkg::hdr_t)),
    .DEPTH(fpa_pkg::POOL_GRANULES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wa_idx[fpa_pkg::MEM_AW-1:0]),
    .wdata(wdata),
    .re   (re_req),
    .raddr(ra_idx[fpa_pkg::MEM_AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      head_ok_r   <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (re_req) begin
        rd_oob_r <= (ra_idx >= GRAN_LIM);
      end
      unique case (cmd.op)
        fpa_pkg::OP_CAPTURE: begin
          func_r <= fpa_pkg::func_t'(in_func);
          req_r  <= in_req_bytes;
          off_r  <= in_free_offset;
          pay_r  <= '0;
        end
        fpa_pkg::OP_FORM: begin
          head_r    <= '0;
          head_ok_r <= (p_eff >= FW'(fpa_pkg::MIN_REST));
        end
        fpa_pkg::OP_W_INIT: begin
          wp_r   <= head_r;
          ok_r   <= head_ok_r;
          hp_r   <= 1'b0;
          n_r    <= '0;
          best_r <= '0;
        end
        fpa_pkg::OP_W_STEP, fpa_pkg::OP_Q_STEP: begin
          hp_r   <= 1'b1;
          pv_r   <= wp_r;
          pvsz_r <= rd.size;
          wp_r   <= rd.next;
          ok_r   <= rd.nok;
          n_r    <= n_r + IW'(1);
          if (cmd.op == fpa_pkg::OP_Q_STEP && rd.size > best_r) begin
            best_r <= rd.size;
          end
        end
        fpa_pkg::OP_A_EVAL: begin
          if (rd.size >= need) begin
            sz_r      <= rd.size;
            nx_r      <= rd.next;
            nok_r     <= rd.nok;
            lnk_tgt_r <= rd.next;
            lnk_ok_r  <= rd.nok;
            pay_r     <= FW'({wp_r, 3'b000}) + FW'(fpa_pkg::HDR_BYTES);
          end else begin
            hp_r   <= 1'b1;
            pv_r   <= wp_r;
            pvsz_r <= rd.size;
            wp_r   <= rd.next;
            ok_r   <= rd.nok;
            n_r    <= n_r + IW'(1);
          end
        end
        fpa_pkg::OP_A_SPL2: begin
          lnk_tgt_r <= r_idx;
          lnk_ok_r  <= 1'b1;
        end
        fpa_pkg::OP_LINK: begin
          if (!hp_r) begin
            head_r    <= lnk_tgt_r;
            head_ok_r <= lnk_ok_r;
          end
        end
        fpa_pkg::OP_F_CUR: cur_r <= IW'(off_r[FW-1:3]) - IW'(1);
        fpa_pkg::OP_F_CSZ: begin
          csz_r <= rd.size;
          wp_r  <= head_r;
          ok_r  <= head_ok_r;
          hp_r  <= 1'b0;
          n_r   <= '0;
        end
        fpa_pkg::OP_F_INS: begin
          w1_r      <= wp_r;
          ok1_r     <= ok_r;
          lnk_tgt_r <= cur_r;
          lnk_ok_r  <= 1'b1;
        end
        fpa_pkg::OP_F_PM: begin
          if (pm_hit) begin
            base_r <= pv_r;
            bsz_r  <= pm_sum;
          end else begin
            base_r <= cur_r;
            bsz_r  <= csz_r;
          end
        end
        fpa_pkg::OP_RESP: begin
          out_valid_r  <= 1'b1;
          out_status_r <= cmd.status;
          out_pay_r    <= pay_r;
          if (func_r != fpa_pkg::FN_QUERY) begin
            out_big_r <= '0;
          end else if (best_r > SW'({FW{1'b1}})) begin
            out_big_r <= '1;
          end else begin
            out_big_r <= best_r[FW-1:0];
          end
        end
        default: ;
      endcase
      // keep the saved predecessor size coherent with writes to that entry
      if (ram_we && wa_idx == pv_r) begin
        pvsz_r <= wdata.size;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_pay_r;
  assign out_largest_free   = out_big_r;

endmodule

/* rtl/first_fit_pool_allocator.sv */
// First-fit pool allocator, top level: configuration register and wiring.
// Depends on fpa_pkg, fpa_ctrl, fpa_dp (and fpa_ram below it).
//
// Usage:
// - Issue a transaction by raising start with in_func, in_req_bytes and
//   in_free_offset while busy is low; the block takes it on that edge.
//   Functions: alloc, free, reset pool, query largest free block.
// - Every transaction yields exactly one result: out_valid pulses for one
//   cycle with out_status, out_payload_offset and out_largest_free. The
//   receiver cannot stall; sample the result on that cycle.
// - busy drops in the same cycle as out_valid, so a new transaction may be
//   issued right then.
// - Steps, accept edge to result edge: a reset pool re-forms the free list,
//   and rejected frees or out-of-range allocs answer straight after their
//   check. An alloc walks the free blocks up to the first fit, with extra
//   header writes when it splits; a failed walk passes the whole list. A
//   free walks the list twice up to the freed address, with an extra step
//   when it merges with its successor. A query walks all free blocks. Each
//   step makes at most one access to the header memory, which bounds the
//   pace of every walk.
// - After rst_n the block forms a single free block over the whole pool in
//   its boot state; busy is high during that state and no result appears.
// - Write pool_bytes through the cfg_ APB port only while idle; it bounds
//   checks at once and shapes the free list at the next pool reset.
module first_fit_pool_allocator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic [fpa_pkg::F_W-1:0] in_req_bytes,
  input  logic [fpa_pkg::F_W-1:0] in_free_offset,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [fpa_pkg::F_W-1:0] out_payload_offset,
  output logic [fpa_pkg::F_W-1:0] out_largest_free,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [fpa_pkg::F_W-1:0] pool_r;
  logic                    cfg_hit;
  fpa_pkg::dp_cmd_t        cmd;
  fpa_pkg::dp_stat_t       stat;

  // register index is the word address; only pool_bytes exists
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (32'(cfg_paddr[2]) == 32'(fpa_pkg::CFG_POOL_IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= fpa_pkg::POOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      pool_r <= cfg_pwdata[fpa_pkg::F_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? 32'(pool_r) : '0;

  fpa_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  fpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_req_bytes      (in_req_bytes),
    .in_free_offset    (in_free_offset),
    .pool_bytes        (pool_r),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_payload_offset(out_payload_offset),
    .out_largest_free  (out_largest_free)
  );

endmodule

/* rtl/fpa_checker.sv */
// Port-level checks of the pool allocator, bound to the top level.
// Depends on fpa_pkg and first_fit_pool_allocator.
module fpa_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [1:0]              out_status,
  input logic [fpa_pkg::F_W-1:0] out_payload_offset
);

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result ends the transaction
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // one result per transaction
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // failed results carry a zero offset
  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fpa_pkg::ST_DONE) |-> (out_payload_offset == '0))
    else $error("failed transaction returned an offset");

endmodule

bind first_fit_pool_allocator fpa_checker u_fpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_payload_offset(out_payload_offset)
);
